// ===== design/svrw_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and fixed field widths for the swap readahead window sizer.
// No dependencies; imported by swap_vma_readahead_window.
package svrw_pkg;

  localparam int PAGE_W      = 36;  // page numbers
  localparam int SLOT_IN_W   = 4;   // region slot field
  localparam int ORDER_W     = 4;   // cluster_order register
  localparam int WIN_FIELD_W = 6;   // window / page count fields, stored window
  localparam int OFFSET_W    = 5;   // fault offset field
  localparam int OUT_PAD_W   = 3;   // zero fill of result word to whole bytes

  localparam logic [ORDER_W-1:0] CLUSTER_ORDER_RESET = 4'd3;
  localparam int                 EMPTY_RECORD_HITS   = 4;  // all-zero record reads so
  localparam int                 MIN_HIT_ORDER       = 2;  // hit windows are >= 4 pages unless the cap is lower

  typedef enum logic {
    FUNC_FAULT = 1'b0,
    FUNC_HIT   = 1'b1
  } func_e;

  // Input word, last field in the low bits.
  typedef struct packed {
    logic [PAGE_W-1:0]    region_end_page;
    logic [PAGE_W-1:0]    region_first_page;
    logic [PAGE_W-1:0]    fault_page;
    logic [SLOT_IN_W-1:0] region_slot;
  } in_item_t;

  // Result word, last field in the low bits.
  typedef struct packed {
    logic [OUT_PAD_W-1:0]   pad;
    logic [OFFSET_W-1:0]    fault_offset;
    logic [WIN_FIELD_W-1:0] page_count;
    logic [PAGE_W-1:0]      run_start_page;
    logic [WIN_FIELD_W-1:0] window;
  } out_item_t;

endpackage

// ===== design/swap_vma_readahead_window.sv =====
`timescale 1ns / 1ps
// Two registers: the input stage, then the output stage that holds the registered result.
// Throughput: one word per cycle unless the output stalls; each word (not a fault at order 0) does one
// record read-modify-write of the flop-based region table in its compute cycle; same-slot hits chain.
// Reset: all region records clear to zero at once (an all-zero record reads as four
// hits), cluster_order resets to 3; no clearing pass, words are taken right after reset.
// Depends on svrw_pkg.
module swap_vma_readahead_window #(
  parameter int REGION_SLOTS         = 16,
  parameter int WINDOW_CEILING_ORDER = 5,
  parameter int BLOCK_PAGES          = 512,
  parameter int HIT_BITS             = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // config write channel: cluster_order
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [svrw_pkg::ORDER_W-1:0] cfg_data_i,
  // input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // tdata: region_slot[3:0], fault_page[39:4], region_first_page[75:40],
  //        region_end_page[111:76]
  input  logic [111:0]                 s_axis_tdata,
  // tuser: func (0 = fault, 1 = hit)
  input  logic                         s_axis_tuser,
  // result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // tdata: window[5:0], run_start_page[41:6], page_count[47:42],
  //        fault_offset[52:48], zero[55:53]
  output logic [55:0]                  m_axis_tdata
);

  import svrw_pkg::*;

  localparam int SLOT_W  = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
  localparam int RAW_N   = 2 ** SLOT_IN_W;
  localparam int WIN_W   = (WINDOW_CEILING_ORDER + 1 > 5) ? WINDOW_CEILING_ORDER + 1 : 5;
  localparam int SUM_W   = HIT_BITS + 1;
  localparam int CMP_W   = (SUM_W > WIN_W) ? SUM_W : WIN_W;
  localparam int EXT_W   = PAGE_W + 1;
  localparam int BLK_W   = $clog2(BLOCK_PAGES);
  localparam logic [HIT_BITS-1:0] HIT_MAX = {HIT_BITS{1'b1}};
  localparam logic [ORDER_W-1:0]  CEIL_ORDER = ORDER_W'(WINDOW_CEILING_ORDER);

  typedef logic [RAW_N-1:0][SLOT_W-1:0] wrap_tbl_t;

  // slot field folded onto the table depth
  function automatic wrap_tbl_t build_wrap();
    wrap_tbl_t tbl;
    for (int i = 0; i < RAW_N; i++) begin
      tbl[i] = SLOT_W'(i % REGION_SLOTS);
    end
    return tbl;
  endfunction

  localparam wrap_tbl_t WRAP_TBL = build_wrap();

  typedef struct packed {
    logic [PAGE_W-1:0]      page;
    logic [WIN_FIELD_W-1:0] win;
    logic [HIT_BITS-1:0]    hits;
  } rec_t;

  // ---------------------------------------------------------------- state
  rec_t                 rec_q [REGION_SLOTS];
  logic [ORDER_W-1:0]   cluster_order_q;

  logic                 s1_valid_q;
  in_item_t             s1_item_q;
  func_e                s1_func_q;

  logic                 out_valid_q;
  out_item_t            out_item_q;

  // ---------------------------------------------------------------- handshake
  logic                 out_free;
  logic                 advance;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = s1_valid_q && out_free;
  assign s_axis_tready = !s1_valid_q || out_free;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_item_q;

  // ---------------------------------------------------------------- compute
  logic [SLOT_W-1:0]    slot;
  rec_t                 rec_raw;
  rec_t                 rec;
  logic [ORDER_W-1:0]   order;
  logic [WIN_W-1:0]     max_win;
  logic [SUM_W-1:0]     hit_sum;
  logic [EXT_W-1:0]     fp_x;
  logic [EXT_W-1:0]     pg_x;
  logic [EXT_W-1:0]     fp_inc;
  logic [EXT_W-1:0]     pg_inc;
  logic                 adjacent;
  logic [WIN_W-1:0]     grown;
  logic [WIN_W-1:0]     half_prev;
  logic [WIN_W-1:0]     win;
  logic [WIN_W-1:0]     left;
  logic [EXT_W-1:0]     win_x;
  logic [EXT_W-1:0]     left_x;
  logic [EXT_W-1:0]     lo;
  logic [EXT_W-1:0]     hi;
  logic [EXT_W-1:0]     blk_x;
  logic [EXT_W-1:0]     blk_end;
  logic [EXT_W-1:0]     start_x;
  logic [EXT_W-1:0]     end_x;
  logic                 run_ok;
  logic                 rec_we;
  rec_t                 rec_d;
  out_item_t            out_item_d;

  always_comb begin
    slot    = WRAP_TBL[s1_item_q.region_slot];
    rec_raw = rec_q[slot];
    rec     = rec_raw;
    if (rec_raw == '0) begin
      rec.hits = HIT_BITS'(EMPTY_RECORD_HITS);
    end

    order   = (cluster_order_q < CEIL_ORDER) ? cluster_order_q : CEIL_ORDER;
    max_win = WIN_W'(1) << order;

    fp_x    = {1'b0, s1_item_q.fault_page};
    pg_x    = {1'b0, rec.page};
    fp_inc  = fp_x + EXT_W'(1);
    pg_inc  = pg_x + EXT_W'(1);

    // sizing: hits+2 rounded up to a power of two (>= 4) and capped, or 1/2 by adjacency; >= half old window
    hit_sum  = SUM_W'(rec.hits) + SUM_W'(2);
    adjacent = (fp_x == pg_inc) || ((rec.page != '0) && (fp_inc == pg_x));
    grown    = max_win;
    for (int k = WINDOW_CEILING_ORDER - 1; k >= MIN_HIT_ORDER; k--) begin
      if ((ORDER_W'(k) < order) && (CMP_W'(hit_sum) <= (CMP_W'(1) << k))) begin
        grown = WIN_W'(1) << k;
      end
    end
    if (rec.hits == '0) begin
      grown = adjacent ? WIN_W'(2) : WIN_W'(1);
    end
    half_prev = WIN_W'(rec.win >> 1);
    win       = (grown < half_prev) ? half_prev : grown;

    // placement: right after ascending step, left after descending, else centred
    win_x  = EXT_W'(win);
    left   = (win - WIN_W'(1)) >> 1;
    left_x = EXT_W'(left);
    if (fp_x == pg_inc) begin
      lo = fp_x;
      hi = fp_x + win_x;
    end else if (pg_x == fp_inc) begin
      lo = (fp_inc >= win_x) ? fp_inc - win_x : '0;
      hi = fp_inc;
    end else begin
      lo = (fp_x >= left_x) ? fp_x - left_x : '0;
      hi = fp_x + win_x - left_x;
    end

    // clamp to region and aligned block
    blk_x   = {1'b0, s1_item_q.fault_page[PAGE_W-1:BLK_W], {BLK_W{1'b0}}};
    blk_end = blk_x + EXT_W'(BLOCK_PAGES);
    start_x = lo;
    if ({1'b0, s1_item_q.region_first_page} > start_x) begin
      start_x = {1'b0, s1_item_q.region_first_page};
    end
    if (blk_x > start_x) begin
      start_x = blk_x;
    end
    end_x = hi;
    if ({1'b0, s1_item_q.region_end_page} < end_x) begin
      end_x = {1'b0, s1_item_q.region_end_page};
    end
    if (blk_end < end_x) begin
      end_x = blk_end;
    end
    run_ok = (end_x > start_x) && (fp_x >= start_x) && (fp_x < end_x);

    rec_we     = 1'b0;
    rec_d      = rec;
    out_item_d = '0;
    if (s1_func_q == FUNC_HIT) begin
      rec_we = 1'b1;
      if (rec.hits < HIT_MAX) begin
        rec_d.hits = rec.hits + HIT_BITS'(1);
      end
    end else if (order == '0) begin
      out_item_d.window = WIN_FIELD_W'(1);
    end else begin
      rec_we            = 1'b1;
      rec_d.page        = s1_item_q.fault_page;
      rec_d.win         = WIN_FIELD_W'(win);
      rec_d.hits        = '0;
      out_item_d.window = WIN_FIELD_W'(win);
      if ((win != WIN_W'(1)) && run_ok) begin
        out_item_d.run_start_page = start_x[PAGE_W-1:0];
        out_item_d.page_count     = WIN_FIELD_W'(end_x - start_x);
        out_item_d.fault_offset   = OFFSET_W'(fp_x - start_x);
      end
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cluster_order_q <= CLUSTER_ORDER_RESET;
      s1_valid_q      <= 1'b0;
      out_valid_q     <= 1'b0;
      for (int i = 0; i < REGION_SLOTS; i++) begin
        rec_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        cluster_order_q <= cfg_data_i;
      end
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
      if (advance && rec_we) begin
        rec_q[slot] <= rec_d;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_item_q <= in_item_t'(s_axis_tdata);
      s1_func_q <= func_e'(s_axis_tuser);
    end
    if (advance) begin
      out_item_q <= out_item_d;
    end
  end

  // ---------------------------------------------------------------- checks
  a_stall_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with a free stage");

  a_skip_zero_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.window == WIN_FIELD_W'(1)) |->
      (out_item_q.page_count == '0 && out_item_q.run_start_page == '0 &&
       out_item_q.fault_offset == '0))
    else $error("skipped window carries a run");

  a_count_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.window != '0) |->
      (out_item_q.page_count <= out_item_q.window))
    else $error("run longer than window");

  a_hit_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_func_q == FUNC_HIT) |=> (rec_q[$past(slot)].hits != '0))
    else $error("hit left a zero hit count");

endmodule
